// ===== hw/rtl/rprop_momentum_weight_update_assert.svh =====
// Assertion macros used by the port-level checker file.
`ifndef RPROP_MOMENTUM_WEIGHT_UPDATE_ASSERT_SVH
`define RPROP_MOMENTUM_WEIGHT_UPDATE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define RMW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Implication checked on every clock edge, reset included
`define RMW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hw/rtl/rmwu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmwu_pkg
// Types, constants and arithmetic helpers of the weight update engine.
// ----------------------------------------------------------------------------
package rmwu_pkg;

    localparam int unsigned NumWeightsDefault = 1024;
    localparam int unsigned IdxW  = 10;
    localparam int unsigned ValW  = 48;
    localparam int unsigned FacW  = 40;
    localparam int unsigned CfgAW = 3;

    // register indexes
    localparam logic [CfgAW-1:0] REG_USE_RPROP    = 3'd0;
    localparam logic [CfgAW-1:0] REG_USE_MOMENTUM = 3'd1;
    localparam logic [CfgAW-1:0] REG_LEARN_RATE   = 3'd2;
    localparam logic [CfgAW-1:0] REG_MOM_COEFF    = 3'd3;
    localparam logic [CfgAW-1:0] REG_ETA_PLUS     = 3'd4;
    localparam logic [CfgAW-1:0] REG_ETA_MINUS    = 3'd5;
    localparam logic [CfgAW-1:0] REG_MAX_STEP     = 3'd6;
    localparam logic [CfgAW-1:0] REG_MIN_STEP     = 3'd7;

    // sign codes
    localparam logic [1:0] SGN_ZERO = 2'd0;
    localparam logic [1:0] SGN_POS  = 2'd1;
    localparam logic [1:0] SGN_NEG  = 2'd2;

    // operation classes chosen by the front end
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_DESC  = 2'd1;
    localparam logic [1:0] OP_RPROP = 2'd2;
    localparam logic [1:0] OP_NULL  = 2'd3;

    localparam logic [FacW-1:0] INIT_POINT_ONE = 40'd429496730;
    localparam logic signed [ValW-1:0] MAX48 = {1'b0, {(ValW-1){1'b1}}};
    localparam logic signed [ValW-1:0] MIN48 = {1'b1, {(ValW-1){1'b0}}};

    typedef struct packed {
        logic [1:0]             op;
        logic                   use_mom;
        logic [IdxW-1:0]        idx;
        logic signed [ValW-1:0] opv;
    } req_t;

    // saturate a 50-bit signed sum to 48 bits
    function automatic logic signed [ValW-1:0] sat50(input logic signed [ValW+1:0] v);
        logic signed [ValW+1:0] hi;
        logic signed [ValW+1:0] lo;
        hi = {{2{MAX48[ValW-1]}}, MAX48};
        lo = {{2{MIN48[ValW-1]}}, MIN48};
        if (v > hi) return MAX48;
        else if (v < lo) return MIN48;
        else return v[ValW-1:0];
    endfunction

endpackage

// ===== hw/rtl/rmwu_mul.sv =====
// ----------------------------------------------------------------------------
// rmwu_mul
// Magnitude times Q8.32 factor, rounded at 32 fraction bits, in two passes.
// Each pass forms one 24x40 partial product; done rises with the registered product.
// ----------------------------------------------------------------------------
module rmwu_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] mag,
    input  logic [39:0] fac,
    output logic        done,
    output logic [87:0] prod
);
    logic [1:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [47:0] mag_reg;
    logic [39:0] fac_reg;
    logic [63:0] lo_reg;
    logic        done_reg;
    logic [87:0] prod_reg;

    assign done = done_reg;
    assign prod = prod_reg;

    // low half first, high half second, round on the last pass
    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= busy_reg && (cnt_reg == 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= mag;
            fac_reg <= fac;
        end else if (busy_reg && cnt_reg == 2'd0) begin
            lo_reg <= {24'd0, 40'(mag_reg[23:0])} * {24'd0, fac_reg};
        end else if (busy_reg && cnt_reg == 2'd1) begin
            prod_reg <= (({24'd0, 64'({40'd0, mag_reg[47:24]} * {24'd0, fac_reg})}
                          << 24) + {24'd0, lo_reg} + 88'h80000000) >> 32;
        end
    end
endmodule

// ===== hw/rtl/rmwu_front.sv =====
// ----------------------------------------------------------------------------
// rmwu_front
// Accepts requests, classifies them and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module rmwu_front #(
    parameter int unsigned NUM_WEIGHTS = rmwu_pkg::NumWeightsDefault
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [9:0]             s_weight_index,
    input  logic signed [47:0]     s_operand_value,
    input  logic                   use_rprop,
    input  logic                   use_momentum,
    input  logic                   q_pop,
    output logic                   q_valid,
    output rmwu_pkg::req_t         q_head
);
    rmwu_pkg::req_t q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    rmwu_pkg::req_t req;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head  = q_reg[rp_reg];

    // classify
    always_comb begin
        req.idx     = s_weight_index;
        req.opv     = s_operand_value;
        req.use_mom = use_momentum;
        if (32'(s_weight_index) >= NUM_WEIGHTS) req.op = rmwu_pkg::OP_NULL;
        else if (!s_cmd)                       req.op = rmwu_pkg::OP_LOAD;
        else if (use_rprop)                    req.op = rmwu_pkg::OP_RPROP;
        else                                   req.op = rmwu_pkg::OP_DESC;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) q_reg[wp_reg] <= req;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (s_valid && s_ready) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, s_valid && s_ready} - {1'b0, q_pop};
        end
    end
endmodule

// ===== hw/rtl/rmwu_back.sv =====
// ----------------------------------------------------------------------------
// rmwu_back
// Sequencer: reads the entry, runs the products, writes back, presents the result.
// ----------------------------------------------------------------------------
module rmwu_back #(
    parameter int unsigned NUM_WEIGHTS = rmwu_pkg::NumWeightsDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  rmwu_pkg::req_t      q_head,
    output logic                q_pop,
    input  logic [39:0]         learning_rate,
    input  logic [39:0]         momentum_coeff,
    input  logic [39:0]         eta_plus,
    input  logic [39:0]         eta_minus,
    input  logic [39:0]         max_step,
    input  logic [39:0]         min_step,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [9:0]          m_out_index,
    output logic signed [47:0]  m_new_weight,
    output logic signed [47:0]  m_applied_change
);
    localparam int unsigned AW = (NUM_WEIGHTS > 1) ?
        (($clog2(NUM_WEIGHTS) < rmwu_pkg::IdxW) ? $clog2(NUM_WEIGHTS) : rmwu_pkg::IdxW) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_M1W  = 3'd3;
    localparam logic [2:0] ST_M2W  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // entry memories
    logic signed [47:0] w_mem [NUM_WEIGHTS];
    logic [39:0]        s_mem [NUM_WEIGHTS];
    logic [1:0]         g_mem [NUM_WEIGHTS];
    logic signed [47:0] c_mem [NUM_WEIGHTS];

    logic [2:0] state_reg, state_next;
    rmwu_pkg::req_t     req_reg;
    logic signed [47:0] w_rd, c_rd, chg_reg, neww_reg;
    logic [39:0]        s_rd, st_reg;
    logic [1:0]         g_rd, sgn_reg;
    logic               we;
    logic [AW-1:0]      addr;

    logic        mul_start;
    logic [47:0] mul_mag;
    logic [39:0] mul_fac;
    logic        mul_done;
    logic [87:0] mul_prod;

    rmwu_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .mag(mul_mag),
        .fac(mul_fac), .done(mul_done), .prod(mul_prod)
    );

    assign addr = req_reg.idx[AW-1:0];
    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign m_valid = (state_reg == ST_OUT);
    assign m_out_index = req_reg.idx;
    assign m_new_weight = neww_reg;
    assign m_applied_change = chg_reg;

    // memory read, registered, held for the whole request
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            w_rd <= w_mem[q_head.idx[AW-1:0]];
            s_rd <= s_mem[q_head.idx[AW-1:0]];
            g_rd <= g_mem[q_head.idx[AW-1:0]];
            c_rd <= c_mem[q_head.idx[AW-1:0]];
        end
    end

    // new weight from the final change
    logic signed [47:0] nsum;
    always_comb nsum = rmwu_pkg::sat50(50'(w_rd) + 50'(chg_reg));

    // write-back data; a load initialises the whole entry
    logic signed [47:0] wr_w, wr_c;
    logic [39:0]        wr_s;
    logic [1:0]         wr_g;
    always_comb begin
        if (req_reg.op == rmwu_pkg::OP_LOAD) begin
            wr_w = req_reg.opv;
            wr_s = rmwu_pkg::INIT_POINT_ONE;
            wr_g = rmwu_pkg::SGN_ZERO;
            wr_c = 48'(rmwu_pkg::INIT_POINT_ONE);
        end else begin
            wr_w = nsum;
            wr_s = st_reg;
            wr_g = sgn_reg;
            wr_c = chg_reg;
        end
    end

    // memory write
    always_ff @(posedge aclk) begin
        if (we) begin
            w_mem[addr] <= wr_w;
            s_mem[addr] <= wr_s;
            g_mem[addr] <= wr_g;
            c_mem[addr] <= wr_c;
        end
    end

    // decode of the read entry
    logic       gz, gneg, same, opp;
    logic [1:0] gsgn;
    logic [1:0] psgn;
    always_comb begin
        gz   = (req_reg.opv == '0);
        gneg = req_reg.opv[47];
        gsgn = gz ? rmwu_pkg::SGN_ZERO : (gneg ? rmwu_pkg::SGN_NEG : rmwu_pkg::SGN_POS);
        psgn = (g_rd == 2'd3) ? rmwu_pkg::SGN_ZERO : g_rd;
        same = !gz && (gsgn == psgn);
        opp  = !gz && (psgn != rmwu_pkg::SGN_ZERO) && (gsgn != psgn);
    end

    // signed product of the multiplier output, saturated
    logic signed [47:0] sprod;
    logic               mneg_reg;
    logic [39:0]        stp;
    always_comb begin
        if (mneg_reg) sprod = (mul_prod > 88'h800000000000) ? rmwu_pkg::MIN48
                               : -$signed(mul_prod[47:0]);
        else sprod = (mul_prod > 88'h7FFFFFFFFFFF) ? rmwu_pkg::MAX48
                      : $signed(mul_prod[47:0]);
        stp = (mul_prod > 88'hFFFFFFFFFF) ? 40'hFFFFFFFFFF : mul_prod[39:0];
    end

    // operand selection for the multiplier
    always_comb begin
        mul_start = 1'b0;
        mul_mag   = '0;
        mul_fac   = learning_rate;
        if (state_reg == ST_READ) begin
            if (req_reg.op == rmwu_pkg::OP_DESC) begin
                mul_start = 1'b1;
                mul_mag = req_reg.opv[47] ? 48'(-req_reg.opv) : req_reg.opv;
            end else if (req_reg.op == rmwu_pkg::OP_RPROP && (same || opp)) begin
                mul_start = 1'b1;
                mul_mag = {8'd0, s_rd};
                mul_fac = same ? eta_plus : eta_minus;
            end
        end else if (state_reg == ST_M1W && mul_done && req_reg.use_mom
                     && req_reg.op == rmwu_pkg::OP_DESC) begin
            mul_start = 1'b1;
            mul_mag = c_rd[47] ? 48'(-c_rd) : c_rd;
            mul_fac = momentum_coeff;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        we = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_READ;
            ST_READ: begin
                if (mul_start) state_next = ST_M1W;
                else state_next = ST_FIN;
            end
            ST_M1W: begin
                if (mul_done) state_next = mul_start ? ST_M2W : ST_FIN;
            end
            ST_M2W: if (mul_done) state_next = ST_FIN;
            ST_FIN: begin
                we = (req_reg.op != rmwu_pkg::OP_NULL);
                state_next = ST_OUT;
            end
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    // datapath registers; for updates FIN adds the final change to the weight
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                req_reg <= q_head;
            end
            ST_READ: begin
                st_reg  <= s_rd;
                sgn_reg <= g_rd;
                chg_reg <= '0;
                mneg_reg <= (req_reg.op == rmwu_pkg::OP_DESC) ? ~req_reg.opv[47] : 1'b0;
                if (req_reg.op == rmwu_pkg::OP_RPROP) begin
                    sgn_reg <= opp ? rmwu_pkg::SGN_ZERO : gsgn;
                    if (opp) chg_reg <= rmwu_pkg::sat50(-50'(c_rd));
                    else if (!same && !gz)
                        chg_reg <= gneg ? $signed({8'd0, s_rd}) : -$signed({8'd0, s_rd});
                    mneg_reg <= 1'b0;
                end
            end
            ST_M1W: if (mul_done) begin
                if (req_reg.op == rmwu_pkg::OP_DESC) begin
                    // negated descent term saturates at minus the largest weight
                    chg_reg  <= (sprod == rmwu_pkg::MIN48) ? -rmwu_pkg::MAX48 : sprod;
                    mneg_reg <= c_rd[47];
                end else if (same) begin
                    st_reg  <= (stp > max_step) ? max_step : stp;
                    chg_reg <= gneg ? $signed({8'd0, ((stp > max_step) ? max_step : stp)})
                                    : -$signed({8'd0, ((stp > max_step) ? max_step : stp)});
                end else begin
                    st_reg <= (stp < min_step) ? min_step : stp;
                end
            end
            ST_M2W: if (mul_done) chg_reg <= rmwu_pkg::sat50(50'(chg_reg) + 50'(sprod));
            ST_FIN: begin
                if (req_reg.op == rmwu_pkg::OP_LOAD) begin
                    neww_reg <= req_reg.opv;
                    chg_reg  <= '0;
                end else if (req_reg.op == rmwu_pkg::OP_NULL) begin
                    neww_reg <= '0;
                    chg_reg  <= '0;
                end else begin
                    neww_reg <= nsum;
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/rprop_momentum_weight_update.sv =====
// A load, an ignored index or an RPROP update with either sign zero needs no multiplier
// pass; descent and RPROP with both signs nonzero need one pass, descent with momentum
// two. Each pass goes through the shared 48x40 multiplier (two 24x40 partial products)
// between the memory read and the write-back. The back end works one request at a time
// and takes the next one in the cycle after the result is accepted; a two-entry queue
// lets the front end accept up to two more while a result waits.
// ----------------------------------------------------------------------------
// rprop_momentum_weight_update
// Per-weight RPROP / gradient-descent-with-momentum update engine, Q15.32.
// ----------------------------------------------------------------------------
module rprop_momentum_weight_update #(
    parameter int unsigned NUM_WEIGHTS = rmwu_pkg::NumWeightsDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [39:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [9:0]         s_weight_index,
    input  logic signed [47:0] s_operand_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [9:0]         m_out_index,
    output logic signed [47:0] m_new_weight,
    output logic signed [47:0] m_applied_change
);
    logic        use_rprop_reg, use_mom_reg;
    logic [39:0] lr_reg, mc_reg, ep_reg, em_reg, mx_reg, mn_reg;
    logic        q_pop, q_valid;
    rmwu_pkg::req_t q_head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_rprop_reg <= 1'b0;
            use_mom_reg   <= 1'b0;
            lr_reg <= 40'd429496730;
            mc_reg <= 40'd0;
            ep_reg <= 40'd5153960755;
            em_reg <= 40'd2147483648;
            mx_reg <= 40'd214748364800;
            mn_reg <= 40'd429;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rmwu_pkg::REG_USE_RPROP:    use_rprop_reg <= cfg_data[0];
                rmwu_pkg::REG_USE_MOMENTUM: use_mom_reg   <= cfg_data[0];
                rmwu_pkg::REG_LEARN_RATE:   lr_reg <= cfg_data;
                rmwu_pkg::REG_MOM_COEFF:    mc_reg <= cfg_data;
                rmwu_pkg::REG_ETA_PLUS:     ep_reg <= cfg_data;
                rmwu_pkg::REG_ETA_MINUS:    em_reg <= cfg_data;
                rmwu_pkg::REG_MAX_STEP:     mx_reg <= cfg_data;
                rmwu_pkg::REG_MIN_STEP:     mn_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rmwu_front #(.NUM_WEIGHTS(NUM_WEIGHTS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_weight_index(s_weight_index), .s_operand_value(s_operand_value),
        .use_rprop(use_rprop_reg), .use_momentum(use_mom_reg),
        .q_pop(q_pop), .q_valid(q_valid), .q_head(q_head)
    );

    rmwu_back #(.NUM_WEIGHTS(NUM_WEIGHTS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
        .learning_rate(lr_reg), .momentum_coeff(mc_reg), .eta_plus(ep_reg),
        .eta_minus(em_reg), .max_step(mx_reg), .min_step(mn_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_index(m_out_index),
        .m_new_weight(m_new_weight), .m_applied_change(m_applied_change)
    );
endmodule

// ===== hw/rtl/rmwu_checker.sv =====
// ----------------------------------------------------------------------------
// rmwu_checker
// Port-level checks of the weight update engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "rprop_momentum_weight_update_assert.svh"
module rmwu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [9:0]  m_out_index,
    input logic [47:0] m_new_weight,
    input logic [47:0] m_applied_change
);
    // result request holds while stalled
    `RMW_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_index), "result dropped while stalled")
    // nothing shown straight out of reset
    `RMW_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_valid, "result valid after reset")
    // stalled change stays put
    `RMW_ASSERT(a_chg, aclk, aresetn, m_valid && !m_ready |=> $stable(m_applied_change), "change moved while stalled")
    // stalled weight stays put
    `RMW_ASSERT(a_wt, aclk, aresetn, m_valid && !m_ready |=> $stable(m_new_weight), "weight changed while stalled")
endmodule

bind rprop_momentum_weight_update rmwu_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_out_index(m_out_index),
    .m_new_weight(m_new_weight), .m_applied_change(m_applied_change)
);

// ===== sim/rmwu_checker.sv =====
// ----------------------------------------------------------------------------
// rmwu_scoreboard
// Watches the request and result channels of the weight update engine, keeps
// its own copy of the per-weight state and registers, works out each result
// and compares it field by field with what the engine returns.
// ----------------------------------------------------------------------------
module rmwu_scoreboard (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [39:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_cmd,
    input  logic [9:0]         s_weight_index,
    input  logic signed [47:0] s_operand_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [9:0]         m_out_index,
    input  logic signed [47:0] m_new_weight,
    input  logic signed [47:0] m_applied_change,
    output int                 fail_count,
    output int                 pending_count
);
    typedef struct packed {
        logic [9:0]         idx;
        logic signed [47:0] weight;
        logic signed [47:0] change;
    } upd_result_t;

    localparam logic signed [63:0] MAXV = 64'sd140737488355327;
    localparam logic signed [63:0] MINV = -64'sd140737488355328;

    // shadow state
    logic signed [47:0] wt_mem [1024];
    logic [39:0]        step_mem [1024];
    logic [1:0]         sgn_mem [1024];
    logic signed [47:0] chg_mem [1024];

    logic        rprop_on, mom_on;
    logic [39:0] lrate, mcoeff, etap, etam, stepmax, stepmin;

    upd_result_t result_q[$];

    function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
        if (v > MAXV) return MAXV[47:0];
        if (v < MINV) return MINV[47:0];
        return v[47:0];
    endfunction

    // magnitude times factor, rounded half up at 32 fraction bits
    function automatic logic [63:0] mag_scale(input logic [47:0] a, input logic [39:0] b);
        logic [87:0] p;
        p = a * b + 88'h80000000;
        return 64'(p[87:32]);
    endfunction

    function automatic logic signed [47:0] scale_q(input logic signed [47:0] v,
                                                   input logic [39:0] f);
        logic [47:0] mag;
        logic [63:0] p;
        mag = v[47] ? 48'(-v) : v;
        p = mag_scale(mag, f);
        if (v[47]) begin
            if (p > 64'h800000000000) return MINV[47:0];
            return 48'(-p);
        end
        if (p > 64'(MAXV)) return MAXV[47:0];
        return p[47:0];
    endfunction

    function automatic logic [39:0] scale_step(input logic [39:0] s, input logic [39:0] f);
        logic [63:0] p;
        p = mag_scale({8'd0, s}, f);
        return (p > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : p[39:0];
    endfunction

    function automatic int sgn_val(input logic [1:0] c);
        if (c == rmwu_pkg::SGN_POS) return 1;
        if (c == rmwu_pkg::SGN_NEG) return -1;
        return 0;
    endfunction

    // apply one request to the shadow state and return its result
    function automatic upd_result_t apply_request(input logic c, input logic [9:0] i,
                                                  input logic signed [47:0] g);
        upd_result_t r;
        logic signed [47:0] chg;
        logic [39:0] st;
        logic [1:0] ns;
        int gs, ps;
        chg = '0;
        r.idx = i;
        if (c == 1'b0) begin
            wt_mem[i] = g; step_mem[i] = rmwu_pkg::INIT_POINT_ONE;
            sgn_mem[i] = rmwu_pkg::SGN_ZERO; chg_mem[i] = 48'(rmwu_pkg::INIT_POINT_ONE);
        end else if (!rprop_on) begin
            chg = clamp48(-64'(scale_q(g, lrate)));
            if (mom_on) chg = clamp48(64'(chg) + 64'(scale_q(chg_mem[i], mcoeff)));
            wt_mem[i] = clamp48(64'(wt_mem[i]) + 64'(chg));
            chg_mem[i] = chg;
        end else begin
            gs = (g > 0) ? 1 : ((g < 0) ? -1 : 0);
            ps = sgn_val(sgn_mem[i]);
            st = step_mem[i];
            ns = (gs > 0) ? rmwu_pkg::SGN_POS
                          : ((gs < 0) ? rmwu_pkg::SGN_NEG : rmwu_pkg::SGN_ZERO);
            if (gs != 0 && gs == ps) begin
                st = scale_step(st, etap);
                if (st > stepmax) st = stepmax;
                chg = (gs > 0) ? -48'(st) : 48'(st);
            end else if (gs != 0 && ps != 0) begin
                st = scale_step(st, etam);
                if (st < stepmin) st = stepmin;
                chg = clamp48(-64'(chg_mem[i]));
                ns = rmwu_pkg::SGN_ZERO;
            end else if (gs != 0) begin
                chg = (gs > 0) ? -48'(st) : 48'(st);
            end
            step_mem[i] = st;
            wt_mem[i] = clamp48(64'(wt_mem[i]) + 64'(chg));
            sgn_mem[i] = ns;
            chg_mem[i] = chg;
        end
        r.weight = wt_mem[i];
        r.change = chg;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        upd_result_t exp_r;
        if (!aresetn) begin
            rprop_on <= 1'b0; mom_on <= 1'b0;
            lrate <= 40'd429496730; mcoeff <= '0;
            etap <= 40'd5153960755; etam <= 40'd2147483648;
            stepmax <= 40'd214748364800; stepmin <= 40'd429;
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    rmwu_pkg::REG_USE_RPROP:    rprop_on <= cfg_data[0];
                    rmwu_pkg::REG_USE_MOMENTUM: mom_on   <= cfg_data[0];
                    rmwu_pkg::REG_LEARN_RATE:   lrate    <= cfg_data;
                    rmwu_pkg::REG_MOM_COEFF:    mcoeff   <= cfg_data;
                    rmwu_pkg::REG_ETA_PLUS:     etap     <= cfg_data;
                    rmwu_pkg::REG_ETA_MINUS:    etam     <= cfg_data;
                    rmwu_pkg::REG_MAX_STEP:     stepmax  <= cfg_data;
                    default:                    stepmin  <= cfg_data;
                endcase
            end
            if (s_valid && s_ready)
                result_q.insert(result_q.size(),
                                apply_request(s_cmd, s_weight_index, s_operand_value));
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result idx=%0d", $time, m_out_index);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = result_q.pop_front();
                    if (exp_r.idx !== m_out_index || exp_r.weight !== m_new_weight ||
                        exp_r.change !== m_applied_change) begin
                        $display("%0t: mismatch exp idx=%0d w=%0d chg=%0d act idx=%0d w=%0d chg=%0d",
                                 $time, exp_r.idx, exp_r.weight, exp_r.change,
                                 m_out_index, m_new_weight, m_applied_change);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= result_q.size();
        end
    end

endmodule

// ===== sim/tb_rprop_momentum_weight_update.sv =====
// ----------------------------------------------------------------------------
// tb_rprop_momentum_weight_update
// Drives load and gradient requests into the engine under several register
// settings and idling patterns; a checker beside the engine predicts results.
// ----------------------------------------------------------------------------
module tb_rprop_momentum_weight_update;
    localparam int CYCLE_LIMIT = 400000;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [39:0]        cfg_data;
    logic               s_valid, s_ready, s_cmd;
    logic [9:0]         s_weight_index;
    logic signed [47:0] s_operand_value;
    logic               m_valid, m_ready;
    logic [9:0]         m_out_index;
    logic signed [47:0] m_new_weight, m_applied_change;
    int                 fail_count, pending_count;
    int                 send_idle_pct, stall_pct, cycle_no;
    bit                 hold_off;
    bit                 loaded [1024];
    logic [9:0]         hot_idx [8];

    rprop_momentum_weight_update u_dut (.*);

    rmwu_scoreboard u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: random stall, or a long hold-off when asked
    always_ff @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always_ff @(posedge aclk) begin
        if (!aresetn) cycle_no <= 0;
        else cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] ri, input logic [39:0] v);
        cfg_we <= 1'b1; cfg_index <= ri; cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // drop the request and wait until every expected result has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // offer one request, honouring the sender idle rate
    task automatic send_request(input logic c, input logic [9:0] i,
                                input logic signed [47:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1; s_cmd <= c; s_weight_index <= i; s_operand_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        loaded[i] = loaded[i] || (c == 1'b0);
    endtask

    function automatic logic signed [47:0] rand_grad();
        case ($urandom_range(5))
            0: return 48'sh7FFF_FFFF_FFFF;
            1: return 48'sh8000_0000_0000;
            2: return '0;
            3: return 48'($signed($urandom_range(200000)) - 100000) <<< $urandom_range(40);
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    // random request; updates only reach entries already loaded
    task automatic send_random();
        logic [9:0] i;
        i = ($urandom_range(3) == 0) ? 10'($urandom) : hot_idx[$urandom_range(7)];
        if (!loaded[i] || $urandom_range(9) == 0) send_request(1'b0, i, rand_grad());
        else send_request(1'b1, i, rand_grad());
    endtask

    task automatic random_regs();
        write_reg(rmwu_pkg::REG_USE_RPROP, 40'($urandom_range(1)));
        write_reg(rmwu_pkg::REG_USE_MOMENTUM, 40'($urandom_range(1)));
        write_reg(rmwu_pkg::REG_LEARN_RATE,
                  ($urandom_range(4) == 0) ? '1 : 40'($urandom) >> $urandom_range(8));
        write_reg(rmwu_pkg::REG_MOM_COEFF, ($urandom_range(4) == 0) ? '1 : 40'($urandom));
        write_reg(rmwu_pkg::REG_ETA_PLUS,
                  ($urandom_range(4) == 0) ? '1 : {8'($urandom_range(3)), 32'($urandom)});
        write_reg(rmwu_pkg::REG_ETA_MINUS, ($urandom_range(4) == 0) ? '0 : 40'($urandom));
        write_reg(rmwu_pkg::REG_MAX_STEP,
                  ($urandom_range(3) == 0) ? '1 : {8'($urandom_range(255)), 32'($urandom)});
        write_reg(rmwu_pkg::REG_MIN_STEP,
                  ($urandom_range(3) == 0) ? '0 : 40'($urandom_range(1 << 20)));
    endtask

    initial begin
        aresetn = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_cmd = 1'b0; s_weight_index = '0; s_operand_value = '0;
        send_idle_pct = 0; stall_pct = 0; hold_off = 1'b0;
        foreach (hot_idx[k]) hot_idx[k] = 10'($urandom);
        hot_idx[0] = '0; hot_idx[1] = 10'd1023;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: loads at the extremes, descent without and with momentum, then RPROP sign cases
        send_request(1'b0, 10'd0, 48'sh7FFF_FFFF_FFFF);
        send_request(1'b0, 10'd1023, 48'sh8000_0000_0000);
        send_request(1'b0, 10'd5, '0);
        send_request(1'b1, 10'd0, 48'sh8000_0000_0000);
        send_request(1'b1, 10'd1023, 48'sh7FFF_FFFF_FFFF);
        send_request(1'b1, 10'd5, 48'sh0001_0000_0000);
        wait_drained();
        write_reg(rmwu_pkg::REG_USE_MOMENTUM, 40'd1);
        write_reg(rmwu_pkg::REG_MOM_COEFF, '1);
        send_request(1'b1, 10'd5, 48'sh0000_8000_0000);
        send_request(1'b1, 10'd0, 48'shFFFF_FFFF_FFFF);
        wait_drained();
        write_reg(rmwu_pkg::REG_USE_RPROP, 40'd1);
        send_request(1'b0, 10'd7, 48'sh0000_0001_0000);
        send_request(1'b1, 10'd7, 48'sh0000_0001_0000);
        send_request(1'b1, 10'd7, 48'sh0000_0002_0000);
        send_request(1'b1, 10'd7, -48'sh0000_0001_0000);
        send_request(1'b1, 10'd7, -48'sh0000_0001_0000);
        send_request(1'b1, 10'd7, '0);
        send_request(1'b1, 10'd7, -48'sh0000_0003_0000);
        send_request(1'b1, 10'd1023, 48'sh7FFF_FFFF_FFFF);
        send_request(1'b1, 10'd1023, 48'sh0000_0000_0001);
        wait_drained();

        // random phases across settings and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            random_regs();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            if (ph == 2) begin
                // receiver holds off while the sender keeps offering
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (60) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 105; n++) begin
                send_random();
                if (ph == 5 && n == 50) wait_drained();
            end
            wait_drained();
        end

        wait_drained();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== rprop_momentum_weight_update.f =====
+incdir+hw/rtl
hw/rtl/rmwu_pkg.sv
hw/rtl/rmwu_mul.sv
hw/rtl/rmwu_front.sv
hw/rtl/rmwu_back.sv
hw/rtl/rprop_momentum_weight_update.sv
hw/rtl/rmwu_checker.sv
sim/rmwu_checker.sv
sim/tb_rprop_momentum_weight_update.sv
